### hdl/rspm_pkg.sv
// Shared constants, types and trig table for the range scan point map builder.
// No dependencies.
package rspm_pkg;

   localparam int MAX_POINTS = 512;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int COORD_W    = 22;
   localparam int TRIG_FRAC  = 15;
   localparam int MUL_W      = 24;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int CSR_W      = 21;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_POSE_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSE_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RANGE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUP_RADIUS = 3'd5;

   typedef logic [TRIG_FRAC:0] trig_rom_type [0:90];

   function automatic trig_rom_type build_rom();
      trig_rom_type rom;
      longint s, c, ns, nc, v;
      longint q [0:90];
      s = 0;
      c = 64'sd1073741824;
      q[0] = 0;
      for (int k = 0; k < 90; k++) begin
         ns = (s * 64'sd1073578288 + c * 64'sd18739379 + 64'sd536870912) >>> 30;
         nc = c;
         if (k < 89) begin
            nc = (c * 64'sd1073578288 - s * 64'sd18739379 + 64'sd536870912) >>> 30;
         end
         s = ns;
         c = nc;
         q[k+1] = s;
      end
      for (int k = 0; k <= 90; k++) begin
         v = q[k];
         if (v > 64'sd1073741824) v = 64'sd1073741824;
         if (v < 0) v = 0;
         v = (v + (64'sd1 <<< (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
         rom[k] = v[TRIG_FRAC:0];
      end
      return rom;
   endfunction

   localparam trig_rom_type SIN_ROM = build_rom();

   function automatic logic signed [TRIG_FRAC+1:0] sin_deg(input logic [8:0] a);
      logic [8:0] r;
      logic signed [TRIG_FRAC+1:0] m;
      r = 9'd0;
      m = '0;
      if (a < 9'd90) begin
         r = a;
         m = $signed({1'b0, SIN_ROM[r[6:0]]});
      end else if (a < 9'd180) begin
         r = 9'd180 - a;
         m = $signed({1'b0, SIN_ROM[r[6:0]]});
      end else if (a < 9'd270) begin
         r = a - 9'd180;
         m = -$signed({1'b0, SIN_ROM[r[6:0]]});
      end else begin
         r = 9'd360 - a;
         m = -$signed({1'b0, SIN_ROM[r[6:0]]});
      end
      return m;
   endfunction

endpackage

### hdl/rspm_if.sv
// Request and response channel interfaces for the point map builder.
// No dependencies.
interface rspm_req_if;
   logic        valid;
   logic        ready;
   logic        scan_start;
   logic [8:0]  scan_angle;
   logic [15:0] range_mm;
   logic        timed_out;
   modport source (output valid, scan_start, scan_angle, range_mm, timed_out, input ready);
   modport sink (input valid, scan_start, scan_angle, range_mm, timed_out, output ready);
endinterface

interface rspm_rsp_if;
   logic               valid;
   logic               ready;
   logic               point_added;
   logic               was_duplicate;
   logic               table_full;
   logic signed [21:0] point_x;
   logic signed [21:0] point_y;
   logic [9:0]         stored_count;
   logic [8:0]         best_angle;
   logic [15:0]        best_range;
   modport source (output valid, point_added, was_duplicate, table_full, point_x, point_y,
                   stored_count, best_angle, best_range, input ready);
   modport sink (input valid, point_added, was_duplicate, table_full, point_x, point_y,
                 stored_count, best_angle, best_range, output ready);
endinterface

### hdl/rspm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rspm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

### hdl/rspm_mul.sv
// Shared signed multiplier with registered product.
// Depends on rspm_pkg.
module rspm_mul (
   input  logic                              clock,
   input  logic signed [rspm_pkg::MUL_W-1:0]  op_a,
   input  logic signed [rspm_pkg::MUL_W-1:0]  op_b,
   output logic signed [rspm_pkg::PROD_W-1:0] prod_ff
);
   import rspm_pkg::*;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end
endmodule

### hdl/range_scan_point_map_builder.sv
// Range scan point map builder: one reading in, one result item out.
// Unmapped readings go from the angle state to the result. Mapped ones take the cos, sin
// and radius products, end there with a full table, else compare each stored point until
// a duplicate, or write the point. One shared multiplier does every product, so one item at
// a time; the next item is accepted the cycle after the result is taken. Reset (synchronous,
// active high) clears the state, point count, best direction, pose and heading.
module range_scan_point_map_builder (
   input  logic                          clock,
   input  logic                          reset,
   rspm_req_if.sink                      req_ch,
   rspm_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [rspm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rspm_pkg::CSR_W-1:0]     csr_data
);
   import rspm_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_ANG  = 4'd1;
   localparam logic [3:0] ST_MCOS = 4'd2;
   localparam logic [3:0] ST_MSIN = 4'd3;
   localparam logic [3:0] ST_MR2  = 4'd4;
   localparam logic [3:0] ST_R2W  = 4'd5;
   localparam logic [3:0] ST_RD   = 4'd6;
   localparam logic [3:0] ST_DX   = 4'd7;
   localparam logic [3:0] ST_DY   = 4'd8;
   localparam logic [3:0] ST_CMP  = 4'd9;
   localparam logic [3:0] ST_WR   = 4'd10;
   localparam logic [3:0] ST_DONE = 4'd11;

   logic [3:0] state_ff, state_in;

   logic signed [20:0] pose_x_ff, pose_y_ff;
   logic [8:0]  heading_ff;
   logic [15:0] min_ff, max_ff;
   logic [9:0]  dup_ff;

   logic [15:0] rng_ff;
   logic        map_ok_ff;
   logic [9:0]  sum_ff;
   logic [8:0]  ang_ff;
   logic [8:0]  best_ang_ff;
   logic [15:0] best_rng_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] idx_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic signed [PROD_W-1:0]  r2_ff, sq_ff;
   logic signed [COORD_W:0]   dy_ff;
   logic added_ff, dup_flag_ff, full_ff;

   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic [2*COORD_W-1:0]     rd_data_ff;

   logic accept;
   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = (state_ff == ST_DONE);

   // angle reduction
   logic [9:0] s1, s2, ca;
   logic [8:0] ang_red, cos_ang;
   always_comb begin
      s1 = (sum_ff >= 10'd360) ? sum_ff - 10'd360 : sum_ff;
      s2 = (s1 >= 10'd360) ? s1 - 10'd360 : s1;
      ang_red = s2[8:0];
      ca = {1'b0, ang_ff} + 10'd90;
      if (ca >= 10'd360) ca = ca - 10'd360;
      cos_ang = ca[8:0];
   end

   // rounding and saturation of the product onto the pose
   function automatic logic signed [COORD_W-1:0] place(input logic signed [20:0] pose,
                                                       input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      logic signed [MUL_W-1:0] t;
      r = (p + (PROD_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      t = MUL_W'(pose) + r[MUL_W-1:0];
      if (t > MUL_W'((1 <<< (COORD_W - 1)) - 1)) t = MUL_W'((1 <<< (COORD_W - 1)) - 1);
      else if (t < -MUL_W'(1 <<< (COORD_W - 1))) t = -MUL_W'(1 <<< (COORD_W - 1));
      return t[COORD_W-1:0];
   endfunction

   logic signed [COORD_W:0] dx_w, dy_w;
   logic signed [PROD_W-1:0] dist2;
   assign dx_w = $signed({rd_data_ff[2*COORD_W-1], rd_data_ff[2*COORD_W-1:COORD_W]}) -
                 (COORD_W+1)'(px_ff);
   assign dy_w = $signed({rd_data_ff[COORD_W-1], rd_data_ff[COORD_W-1:0]}) - (COORD_W+1)'(py_ff);
   assign dist2 = sq_ff + prod_ff;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_MCOS: begin
            op_a = $signed({{(MUL_W-16){1'b0}}, rng_ff});
            op_b = MUL_W'(sin_deg(cos_ang));
         end
         ST_MSIN: begin
            op_a = $signed({{(MUL_W-16){1'b0}}, rng_ff});
            op_b = MUL_W'(sin_deg(ang_ff));
         end
         ST_MR2: begin
            op_a = $signed({{(MUL_W-10){1'b0}}, dup_ff});
            op_b = $signed({{(MUL_W-10){1'b0}}, dup_ff});
         end
         ST_DX: begin
            op_a = MUL_W'(dx_w);
            op_b = MUL_W'(dx_w);
         end
         ST_DY: begin
            op_a = MUL_W'(dy_ff);
            op_b = MUL_W'(dy_ff);
         end
         default: begin
         end
      endcase
   end

   rspm_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   rspm_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_map (
      .clock      (clock),
      .wr_en      (state_ff == ST_WR),
      .wr_addr    (count_ff[IDX_W-1:0]),
      .wr_data    ({px_ff, py_ff}),
      .rd_addr    (idx_ff),
      .rd_data_ff (rd_data_ff)
   );

   logic last_pt;
   assign last_pt = ({1'b0, idx_ff} + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_ANG;
         ST_ANG:  state_in = map_ok_ff ? ST_MCOS : ST_DONE;
         ST_MCOS: state_in = ST_MSIN;
         ST_MSIN: state_in = ST_MR2;
         ST_MR2:  state_in = ST_R2W;
         ST_R2W: begin
            if (count_ff == CNT_W'(MAX_POINTS)) state_in = ST_DONE;
            else if (count_ff == '0) state_in = ST_WR;
            else state_in = ST_RD;
         end
         ST_RD:   state_in = ST_DX;
         ST_DX:   state_in = ST_DY;
         ST_DY:   state_in = ST_CMP;
         ST_CMP: begin
            if (dist2 < r2_ff) state_in = ST_DONE;
            else if (last_pt) state_in = ST_WR;
            else state_in = ST_RD;
         end
         ST_WR:   state_in = ST_DONE;
         ST_DONE: if (rsp_ch.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   logic [15:0] best_base;
   assign best_base = req_ch.scan_start ? 16'd0 : best_rng_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pose_x_ff   <= '0;
         pose_y_ff   <= '0;
         heading_ff  <= '0;
         min_ff      <= 16'd30;
         max_ff      <= 16'd2000;
         dup_ff      <= 10'd50;
         count_ff    <= '0;
         best_ang_ff <= '0;
         best_rng_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POSE_X:     pose_x_ff  <= $signed(csr_data);
               CSR_POSE_Y:     pose_y_ff  <= $signed(csr_data);
               CSR_HEADING:    heading_ff <= csr_data[8:0];
               CSR_MIN_RANGE:  min_ff     <= csr_data[15:0];
               CSR_MAX_RANGE:  max_ff     <= csr_data[15:0];
               CSR_DUP_RADIUS: dup_ff     <= csr_data[9:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            if (!req_ch.timed_out && req_ch.range_mm > best_base && req_ch.range_mm < max_ff) begin
               best_rng_ff <= req_ch.range_mm;
               best_ang_ff <= req_ch.scan_angle;
            end else if (req_ch.scan_start) begin
               best_rng_ff <= '0;
               best_ang_ff <= '0;
            end
         end
         if (state_ff == ST_WR) count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rng_ff      <= req_ch.range_mm;
         map_ok_ff   <= !req_ch.timed_out && req_ch.range_mm > min_ff &&
                        req_ch.range_mm < max_ff;
         sum_ff      <= {1'b0, req_ch.scan_angle} + {1'b0, heading_ff};
         px_ff       <= '0;
         py_ff       <= '0;
         added_ff    <= 1'b0;
         dup_flag_ff <= 1'b0;
         full_ff     <= 1'b0;
      end
      case (state_ff)
         ST_ANG:  ang_ff <= ang_red;
         ST_MSIN: px_ff  <= place(pose_x_ff, prod_ff);
         ST_MR2:  py_ff  <= place(pose_y_ff, prod_ff);
         ST_R2W: begin
            r2_ff  <= prod_ff;
            idx_ff <= '0;
            if (count_ff == CNT_W'(MAX_POINTS)) full_ff <= 1'b1;
         end
         ST_DX:   dy_ff <= dy_w;
         ST_DY:   sq_ff <= prod_ff;
         ST_CMP: begin
            if (dist2 < r2_ff) dup_flag_ff <= 1'b1;
            idx_ff <= idx_ff + IDX_W'(1);
         end
         ST_WR:   added_ff <= 1'b1;
         default: begin
         end
      endcase
   end

   assign rsp_ch.point_added   = added_ff;
   assign rsp_ch.was_duplicate = dup_flag_ff;
   assign rsp_ch.table_full    = full_ff;
   assign rsp_ch.point_x       = px_ff;
   assign rsp_ch.point_y       = py_ff;
   assign rsp_ch.stored_count  = count_ff;
   assign rsp_ch.best_angle    = best_ang_ff;
   assign rsp_ch.best_range    = best_rng_ff;

   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready) else $error("ready while result pending");
   a_count_lim: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS)) else $error("point count overflow");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> $countones({added_ff, dup_flag_ff, full_ff}) <= 1)
      else $error("conflicting result flags");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("store did not advance count");
endmodule
